// ----- rtl/core/ecpm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Energy counter power meter package
// Shared widths, domain codes and the sequencer state type.
// ----------------------------------------------------------------------------
package ecpm_pkg;

  localparam int DEF_NUM_SLOTS = 32;

  localparam int DOM_W  = 3;
  localparam int SLOT_W = 5;
  localparam int CNT_W  = 64;
  localparam int PWR_W  = 32;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 192;

  // Energy delta times nine, the numerator before its shift by fifteen.
  localparam int NUM_W = CNT_W + 4;
  // Time delta times one hundred twenty-five.
  localparam int DEN_W = CNT_W + 7;
  // Numerator shifted right by seventeen.
  localparam int NUM_HI_W = NUM_W - 17;

  localparam logic [DOM_W-1:0] DOM_PACKAGE  = 3'd0;
  localparam logic [DOM_W-1:0] DOM_CORE_AGG = 3'd1;
  localparam logic [DOM_W-1:0] DOM_PER_CORE = 3'd2;
  localparam logic [DOM_W-1:0] DOM_GPU      = 3'd3;
  localparam logic [DOM_W-1:0] DOM_DRAM     = 3'd4;

  localparam logic [PWR_W-1:0] PWR_MAX = '1;

  localparam logic [4:0] DIV_LAST = 5'd31;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP1,
    ST_PREP2,
    ST_PREP3,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_ROUND,
    ST_EMIT
  } ecpm_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/energy_counter_power_meter.sv -----
// Timing: a reading with a valid history passes through PREP1, PREP2, PREP3,
// CHECK, the 32-step shared restoring divider and UPDATE before the next reading
// is accepted; a first or non-increasing reading skips from PREP2 to UPDATE, a
// saturating one from CHECK to UPDATE, and an unused domain is dropped in IDLE.
// A round end adds ROUND and EMIT, and EMIT waits for the output to be free.
// Reset (synchronous, rst_n low) invalidates all histories and clears the powers and the config.
`default_nettype none
// ----------------------------------------------------------------------------
// Energy counter power meter
// Turns per-slot energy counter readings into domain powers and emits a
// summary word of all domain powers at every round end.
// ----------------------------------------------------------------------------
module energy_counter_power_meter
  import ecpm_pkg::*;
#(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // domain [2:0], slot [7:3], energy [71:8], timestamp [135:72]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // package_power [31:0], core_power [63:32], gpu_power [95:64],
  // dram_power [127:96], component_power [159:128], total_power [191:160]
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  ecpm_state_t state_r, state_nxt;

  logic core_source_r;

  logic [CNT_W-1:0] mem_e [NUM_SLOTS];
  logic [CNT_W-1:0] mem_t [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_r;

  logic [IDX_W-1:0] slot_map [32];
  logic [IDX_W-1:0] in_idx;
  logic [DOM_W-1:0] in_domain;
  logic [CNT_W-1:0] in_energy;
  logic [CNT_W-1:0] in_stamp;
  logic             in_acc;

  logic [DOM_W-1:0] dom_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] eng_r;
  logic [CNT_W-1:0] tim_r;
  logic             eor_r;
  logic [CNT_W-1:0] pe_r;
  logic [CNT_W-1:0] pt_r;
  logic             pv_r;
  logic [CNT_W-1:0] de_r;
  logic [CNT_W-1:0] dt_r;
  logic             zero_r;
  logic [NUM_W-1:0] n_r;
  logic [DEN_W-1:0] d_r;
  logic [DEN_W-1:0] rem_r;
  logic [PWR_W-1:0] nlo_r;
  logic [PWR_W-1:0] q_r;
  logic [4:0]       cnt_r;

  logic [PWR_W-1:0] pkg_r, core_r, gpu_r, dram_r, core_sum_r;
  logic             out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [DEN_W:0]   trial;
  logic             trial_ge;
  logic             ovf;
  logic [PWR_W:0]   sum_sat;
  logic [PWR_W:0]   acc_cg;
  logic [PWR_W+1:0] tot_sum;
  logic [PWR_W-1:0] comp_pwr;
  logic [PWR_W-1:0] tot_pwr;
  logic             out_free;
  logic             work_dom;

  for (genvar v = 0; v < 32; v++) begin : g_slot_map
    assign slot_map[v] = IDX_W'(v % NUM_SLOTS);
  end

  assign in_domain = in_tdata[2:0];
  assign in_idx    = slot_map[in_tdata[7:3]];
  assign in_energy = in_tdata[71:8];
  assign in_stamp  = in_tdata[135:72];
  assign in_acc    = in_tvalid && in_tready;
  assign work_dom  = (in_domain <= DOM_DRAM);

  assign trial    = {rem_r, nlo_r[PWR_W-1]};
  assign trial_ge = (trial >= {1'b0, d_r});
  assign ovf      = ({{(DEN_W-NUM_HI_W){1'b0}}, n_r[NUM_W-1:17]} >= d_r);
  assign sum_sat  = {1'b0, core_sum_r} + {1'b0, q_r};
  assign acc_cg   = {1'b0, core_r} + {1'b0, gpu_r};
  assign tot_sum  = {2'b00, pkg_r} + {2'b00, gpu_r} + {2'b00, dram_r};
  assign comp_pwr = (({1'b0, pkg_r} > acc_cg) && (acc_cg != '0))
                    ? PWR_W'({1'b0, pkg_r} - acc_cg) : '0;
  assign tot_pwr  = (tot_sum > {2'b00, PWR_MAX}) ? PWR_MAX : tot_sum[PWR_W-1:0];
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (work_dom) state_nxt = ST_PREP1;
          else if (in_tlast) state_nxt = ST_ROUND;
        end
      end
      ST_PREP1: state_nxt = ST_PREP2;
      ST_PREP2: state_nxt = zero_r ? ST_UPDATE : ST_PREP3;
      ST_PREP3: state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = ovf ? ST_UPDATE : ST_DIV;
      ST_DIV: begin
        if (cnt_r == DIV_LAST) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: state_nxt = eor_r ? ST_ROUND : ST_IDLE;
      ST_ROUND: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      core_source_r <= 1'b0;
      valid_r       <= '0;
      pkg_r         <= '0;
      core_r        <= '0;
      gpu_r         <= '0;
      dram_r        <= '0;
      core_sum_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) core_source_r <= cfg_wdata;
      if ((state_r == ST_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_PREP1: valid_r[idx_r] <= 1'b1;
        ST_UPDATE: begin
          unique case (dom_r)
            DOM_PACKAGE:  pkg_r <= q_r;
            DOM_CORE_AGG: if (!core_source_r) core_r <= q_r;
            DOM_PER_CORE: begin
              if (core_source_r) begin
                core_sum_r <= sum_sat[PWR_W] ? PWR_MAX : sum_sat[PWR_W-1:0];
              end
            end
            DOM_GPU:      gpu_r <= q_r;
            default:      dram_r <= q_r;
          endcase
        end
        ST_ROUND: begin
          if (core_source_r) core_r <= core_sum_r;
          core_sum_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pe_r <= mem_e[in_idx];
      pt_r <= mem_t[in_idx];
    end
    if (state_r == ST_PREP1) begin
      mem_e[idx_r] <= eng_r;
      mem_t[idx_r] <= tim_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dom_r <= in_domain;
      idx_r <= in_idx;
      eng_r <= in_energy;
      tim_r <= in_stamp;
      eor_r <= in_tlast;
      pv_r  <= valid_r[in_idx];
    end
    unique case (state_r)
      ST_PREP1: begin
        de_r   <= eng_r - pe_r;
        dt_r   <= tim_r - pt_r;
        zero_r <= !pv_r || (pe_r == '0) || (pt_r == '0) ||
                  (eng_r <= pe_r) || (tim_r <= pt_r);
      end
      ST_PREP2: begin
        if (zero_r) begin
          q_r <= '0;
        end else begin
          n_r <= {1'b0, de_r, 3'b000} + {4'b0000, de_r};
          d_r <= {dt_r, 7'b0} - {3'b000, dt_r, 4'b0} + DEN_W'(0);
        end
      end
      ST_PREP3: d_r <= d_r + {7'b0, dt_r} - {5'b0, dt_r, 2'b00} + {3'b000, dt_r, 4'b0};
      ST_CHECK: begin
        q_r   <= ovf ? PWR_MAX : '0;
        rem_r <= {{(DEN_W-NUM_HI_W){1'b0}}, n_r[NUM_W-1:17]};
        nlo_r <= {n_r[16:0], 15'b0};
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= trial_ge ? DEN_W'(trial - {1'b0, d_r}) : trial[DEN_W-1:0];
        q_r   <= {q_r[PWR_W-2:0], trial_ge};
        nlo_r <= {nlo_r[PWR_W-2:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_data_r <= {tot_pwr, comp_pwr, dram_r, gpu_r, core_r, pkg_r};
        end
      end
      default: ;
    endcase
  end

  // A valid reading always enters the sequencer on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && work_dom) |=> (state_r == ST_PREP1))
    else $error("accepted reading did not start processing");

  // The partial remainder stays below the divisor during division.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < d_r))
    else $error("divider remainder out of range");

  // The divider runs all of its steps before leaving.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r != DIV_LAST) |=> (state_r == ST_DIV))
    else $error("divider left early");

  // The per-core sum is cleared at every round end.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |=> (core_sum_r == '0))
    else $error("per-core sum not cleared at round end");

  // A result word only appears out of the emit step.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result word raised outside emit");

endmodule
`default_nettype wire
